[rtl/text_console_cursor_scroll_defines.svh]
// Assertion macros shared by the text console RTL.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcs_pkg.sv]
// Shared constants, types and helpers of the text console.
package tcs_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_COUNT  = CELL_COUNT - SCREEN_COLS;

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
    endfunction

endpackage

[rtl/text_console_cursor_scroll.sv]
// Text console engine: screen store, cursor, scroll and clear sweeps.
// A put-character, read or unused-action transaction passes through the done state to the
// registered result outputs, and the next transaction is not accepted until that result is issued.
// A clear or a scroll sweeps the store one cell per cycle, then passes through the done state
// to the result, with input stalled throughout.
// After reset a clearing pass over every cell fills the store with blanks; input stalls
// meanwhile and until its last blank is written, while attribute writes are taken at any time.
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] char_code,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] cursor_row_now,
    output logic [6:0] cursor_col_now,
    output logic [7:0] cell_char,
    output logic [7:0] cell_attr,
    output logic       scrolled
);

    localparam int RW = tcs_pkg::ROW_W;
    localparam int CW = tcs_pkg::COL_W;
    localparam int AW = tcs_pkg::ADDR_W;

    logic [15:0] mem [tcs_pkg::CELL_COUNT];
    logic [15:0] rdata_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    tcs_pkg::state_t state_reg, state_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [7:0]    attr_reg;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          sweep_copy_reg, sweep_copy_next;
    logic [7:0]    sweep_attr_reg, sweep_attr_next;
    logic          p_valid_reg, p_valid_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic          p_copy_reg, p_copy_next;
    logic          res_read_reg, res_read_next;
    logic          res_scroll_reg, res_scroll_next;
    logic          out_valid_reg, out_valid_next;
    logic [4:0]    out_row_reg, out_row_next;
    logic [6:0]    out_col_reg, out_col_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic [7:0]    out_attr_reg, out_attr_next;
    logic          out_scroll_reg, out_scroll_next;

    logic in_acc;
    logic out_free;

    assign in_stall = (state_reg != tcs_pkg::ST_IDLE) || p_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign cursor_row_now = out_row_reg;
    assign cursor_col_now = out_col_reg;
    assign cell_char      = out_char_reg;
    assign cell_attr      = out_attr_reg;
    assign scrolled       = out_scroll_reg;

    // Screen store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcs_pkg::ST_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            attr_reg       <= tcs_pkg::ATTR_DEFAULT;
            cnt_reg        <= '0;
            sweep_copy_reg <= 1'b0;
            sweep_attr_reg <= tcs_pkg::ATTR_DEFAULT;
            p_valid_reg    <= 1'b0;
            p_copy_reg     <= 1'b0;
            res_read_reg   <= 1'b0;
            res_scroll_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            cnt_reg        <= cnt_next;
            sweep_copy_reg <= sweep_copy_next;
            sweep_attr_reg <= sweep_attr_next;
            p_valid_reg    <= p_valid_next;
            p_copy_reg     <= p_copy_next;
            res_read_reg   <= res_read_next;
            res_scroll_reg <= res_scroll_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg     <= p_addr_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        out_scroll_reg <= out_scroll_next;
    end

    always_comb
    begin
        logic [RW:0]   row_w;
        logic [CW:0]   col_inc;
        logic [CW-1:0] col_n;
        logic          copy_now;

        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        cnt_next        = cnt_reg;
        sweep_copy_next = sweep_copy_reg;
        sweep_attr_next = sweep_attr_reg;
        p_valid_next    = 1'b0;
        p_addr_next     = cnt_reg;
        p_copy_next     = 1'b0;
        res_read_next   = res_read_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        out_scroll_next = out_scroll_reg;

        row_w    = {1'b0, cur_row_reg};
        col_inc  = {1'b0, cur_col_reg} + (CW+1)'(1);
        col_n    = cur_col_reg;
        copy_now = 1'b0;

        mem_re    = 1'b0;
        mem_raddr = '0;
        // The second half of a sweep step: copy the row below, or write a blank.
        mem_we    = p_valid_reg;
        mem_waddr = p_addr_reg;
        mem_wdata = p_copy_reg ? rdata_reg : {sweep_attr_reg, tcs_pkg::CH_BLANK};

        case (state_reg)
            tcs_pkg::ST_INIT, tcs_pkg::ST_SWEEP:
            begin
                copy_now     = sweep_copy_reg && (int'(cnt_reg) < tcs_pkg::COPY_COUNT);
                p_valid_next = 1'b1;
                p_copy_next  = copy_now;
                if (copy_now)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + AW'(tcs_pkg::SCREEN_COLS);
                end
                if (int'(cnt_reg) == tcs_pkg::CELL_COUNT - 1)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == tcs_pkg::ST_INIT) ? tcs_pkg::ST_IDLE
                                                                : tcs_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_read_next   = 1'b0;
                    res_scroll_next = 1'b0;
                    state_next      = tcs_pkg::ST_DONE;
                    case (action)
                        tcs_pkg::ACT_PUT:
                        begin
                            if (char_code == tcs_pkg::CH_NEWLINE)
                            begin
                                row_w = {1'b0, cur_row_reg} + (RW+1)'(1);
                                col_n = '0;
                            end
                            else if (char_code == tcs_pkg::CH_BACKSPACE)
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    col_n = cur_col_reg - CW'(1);
                                end
                                else if (cur_row_reg != '0)
                                begin
                                    row_w = {1'b0, cur_row_reg} - (RW+1)'(1);
                                    col_n = CW'(tcs_pkg::SCREEN_COLS - 1);
                                end
                                mem_we    = 1'b1;
                                mem_waddr = tcs_pkg::cell_addr(row_w[RW-1:0], col_n);
                                mem_wdata = {attr_reg, tcs_pkg::CH_BLANK};
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = tcs_pkg::cell_addr(cur_row_reg, cur_col_reg);
                                mem_wdata = {attr_reg, char_code};
                                if (col_inc == (CW+1)'(tcs_pkg::SCREEN_COLS))
                                begin
                                    col_n = '0;
                                    row_w = {1'b0, cur_row_reg} + (RW+1)'(1);
                                end
                                else
                                begin
                                    col_n = col_inc[CW-1:0];
                                end
                            end
                            cur_col_next = col_n;
                            if (row_w == (RW+1)'(tcs_pkg::SCREEN_ROWS))
                            begin
                                // Cursor fell off the bottom: scroll the store up one row.
                                cur_row_next    = RW'(tcs_pkg::SCREEN_ROWS - 1);
                                res_scroll_next = 1'b1;
                                sweep_copy_next = 1'b1;
                                sweep_attr_next = attr_reg;
                                cnt_next        = '0;
                                state_next      = tcs_pkg::ST_SWEEP;
                            end
                            else
                            begin
                                cur_row_next = row_w[RW-1:0];
                            end
                        end
                        tcs_pkg::ACT_CLEAR:
                        begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            sweep_copy_next = 1'b0;
                            sweep_attr_next = attr_reg;
                            cnt_next        = '0;
                            state_next      = tcs_pkg::ST_SWEEP;
                        end
                        tcs_pkg::ACT_READ:
                        begin
                            if (int'(cell_row) < tcs_pkg::SCREEN_ROWS &&
                                int'(cell_col) < tcs_pkg::SCREEN_COLS)
                            begin
                                mem_re        = 1'b1;
                                mem_raddr     = tcs_pkg::cell_addr(RW'(cell_row), CW'(cell_col));
                                res_read_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_read_next = 1'b0;
                        end
                    endcase
                end
            end

            tcs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = 5'(cur_row_reg);
                    out_col_next    = 7'(cur_col_reg);
                    out_char_next   = res_read_reg ? rdata_reg[7:0] : 8'd0;
                    out_attr_next   = res_read_reg ? rdata_reg[15:8] : 8'd0;
                    out_scroll_next = res_scroll_reg;
                    state_next      = tcs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    `TCS_ASSERT_IMP(a_no_write_clash, p_valid_reg, !in_acc, "sweep write overlaps a transaction")
    `TCS_ASSERT_IMP(a_cursor_in_range, state_reg == tcs_pkg::ST_IDLE,
                    int'(cur_row_reg) < tcs_pkg::SCREEN_ROWS &&
                    int'(cur_col_reg) < tcs_pkg::SCREEN_COLS, "cursor off screen")
    `TCS_ASSERT_IMP(a_scroll_last_row, state_reg == tcs_pkg::ST_DONE && res_scroll_reg,
                    int'(cur_row_reg) == tcs_pkg::SCREEN_ROWS - 1,
                    "scroll left cursor off the last row")
    `TCS_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "second transaction taken while busy")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the text console: cursor motion, scrolling, clear and cell reads.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         PHASE_ITEMS    = 325;

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] at;
        logic       scr;
    } console_result_t;

    // Tracks the screen, cursor and attribute, and holds the results still owed by the block.
    class console_scoreboard;
        logic [15:0]     cells [tcs_pkg::CELL_COUNT];
        int              pos_row;
        int              pos_col;
        logic [7:0]      attr;
        console_result_t owed_q [$];
        int              errors;
        int              checked;
        int              scroll_count;
        int              clear_count;
        int              read_count;

        function new();
            attr = tcs_pkg::ATTR_DEFAULT;
            fill_blank();
            pos_row = 0;
            pos_col = 0;
        endfunction

        function void fill_blank();
            foreach (cells[i]) cells[i] = {attr, tcs_pkg::CH_BLANK};
        endfunction

        function void set_attribute(logic [7:0] v);
            attr = v;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] code, logic [4:0] rrow,
                                logic [6:0] rcol);
            console_result_t res;
            logic [15:0]     entry;
            res = '0;
            case (act)
                tcs_pkg::ACT_PUT:
                begin
                    if (code == tcs_pkg::CH_NEWLINE)
                    begin
                        pos_row++;
                        pos_col = 0;
                    end
                    else if (code == tcs_pkg::CH_BACKSPACE)
                    begin
                        if (pos_col > 0)
                        begin
                            pos_col--;
                        end
                        else if (pos_row > 0)
                        begin
                            pos_row--;
                            pos_col = tcs_pkg::SCREEN_COLS - 1;
                        end
                        cells[pos_row * tcs_pkg::SCREEN_COLS + pos_col] =
                            {attr, tcs_pkg::CH_BLANK};
                    end
                    else
                    begin
                        cells[pos_row * tcs_pkg::SCREEN_COLS + pos_col] = {attr, code};
                        pos_col++;
                        if (pos_col >= tcs_pkg::SCREEN_COLS)
                        begin
                            pos_col = 0;
                            pos_row++;
                        end
                    end
                    // Falling off the bottom moves every row up by one.
                    if (pos_row >= tcs_pkg::SCREEN_ROWS)
                    begin
                        for (int i = 0; i < tcs_pkg::COPY_COUNT; i++)
                        begin
                            cells[i] = cells[i + tcs_pkg::SCREEN_COLS];
                        end
                        for (int i = tcs_pkg::COPY_COUNT; i < tcs_pkg::CELL_COUNT; i++)
                        begin
                            cells[i] = {attr, tcs_pkg::CH_BLANK};
                        end
                        pos_row = tcs_pkg::SCREEN_ROWS - 1;
                        res.scr = 1'b1;
                        scroll_count++;
                    end
                end
                tcs_pkg::ACT_CLEAR:
                begin
                    fill_blank();
                    pos_row = 0;
                    pos_col = 0;
                    clear_count++;
                end
                tcs_pkg::ACT_READ:
                begin
                    if (rrow < tcs_pkg::SCREEN_ROWS && rcol < tcs_pkg::SCREEN_COLS)
                    begin
                        entry  = cells[rrow * tcs_pkg::SCREEN_COLS + rcol];
                        res.ch = entry[7:0];
                        res.at = entry[15:8];
                        read_count++;
                    end
                end
                default: ;
            endcase
            res.row = pos_row[4:0];
            res.col = pos_col[6:0];
            owed_q.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (owed_q.size() == 0)
            begin
                $error("result arrived with no transaction outstanding");
                errors++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            compare_field("cursor_row_now", want.row, got.row);
            compare_field("cursor_col_now", want.col, got.col);
            compare_field("cell_char", want.ch, got.ch);
            compare_field("cell_attr", want.at, got.at);
            compare_field("scrolled", want.scr, got.scr);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [7:0] cfg_write_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = 2'd0;
    logic [7:0] char_code = 8'h00;
    logic [4:0] cell_row = 5'd0;
    logic [6:0] cell_col = 7'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [4:0] cursor_row_now;
    logic [6:0] cursor_col_now;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;

    console_scoreboard sb = new();
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                quiet_cycles = 0;

    text_console_cursor_scroll i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .char_code      (char_code),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_row_now (cursor_row_now),
        .cursor_col_now (cursor_col_now),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr),
        .scrolled       (scrolled)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        console_result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.row = cursor_row_now;
                got.col = cursor_col_now;
                got.ch  = cell_char;
                got.at  = cell_attr;
                got.scr = scrolled;
                sb.check_result(got);
            end
            if (in_valid && !in_stall)
                sb.note_item(action, char_code, cell_row, cell_col);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog expired with %0d results outstanding", sb.pending());
                    $display("text_console_cursor_scroll: mismatch");
                    $finish;
                end
            end
        end
    end

    // Returns at the edge where the transaction is taken; valid is left high.
    task automatic send_item(logic [1:0] act, logic [7:0] code, logic [4:0] rr,
                             logic [6:0] rc);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        char_code <= code;
        cell_row  <= rr;
        cell_col  <= rc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic put_char(logic [7:0] code);
        send_item(tcs_pkg::ACT_PUT, code, 5'($urandom_range(31)), 7'($urandom_range(127)));
    endtask

    task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
        send_item(tcs_pkg::ACT_READ, 8'($urandom_range(255)), rr, rc);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_attribute(logic [7:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_attribute(v);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int item_goal);
        int done;
        int kind;
        int n;
        int r;
        int near_row;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        done = 0;
        while (done < item_goal)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                // Running text with an occasional line break.
                n = $urandom_range(1, 60);
                repeat (n)
                begin
                    if ($urandom_range(99) < 6)
                        put_char(tcs_pkg::CH_NEWLINE);
                    else
                        put_char(8'($urandom_range(255)));
                end
                done += n;
            end
            else if (kind < 50)
            begin
                n = $urandom_range(1, 6);
                repeat (n) put_char(tcs_pkg::CH_NEWLINE);
                done += n;
            end
            else if (kind < 60)
            begin
                n = $urandom_range(1, 90);
                repeat (n) put_char(tcs_pkg::CH_BACKSPACE);
                done += n;
            end
            else if (kind < 80)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    r = $urandom_range(9);
                    if (r < 5)
                    begin
                        read_cell(5'($urandom_range(tcs_pkg::SCREEN_ROWS - 1)),
                                  7'($urandom_range(tcs_pkg::SCREEN_COLS - 1)));
                    end
                    else if (r < 9)
                    begin
                        // Rows around the cursor hold the freshest text.
                        near_row = sb.pos_row - int'($urandom_range(2));
                        if (near_row < 0) near_row = 0;
                        read_cell(5'(near_row), 7'($urandom_range(tcs_pkg::SCREEN_COLS - 1)));
                    end
                    else
                    begin
                        read_cell(5'($urandom_range(31)), 7'($urandom_range(127)));
                    end
                end
                done += n;
            end
            else if (kind < 86)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(ACT_UNUSED, 8'($urandom_range(255)), 5'($urandom_range(31)),
                              7'($urandom_range(127)));
            end
            else if (kind < 89)
            begin
                send_item(tcs_pkg::ACT_CLEAR, 8'($urandom_range(255)),
                          5'($urandom_range(31)), 7'($urandom_range(127)));
                done++;
            end
            else if (kind < 91)
            begin
                drain_results();
            end
            else
            begin
                send_item(2'($urandom_range(2)), 8'($urandom_range(255)),
                          5'($urandom_range(31)), 7'($urandom_range(127)));
                done++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, corners and out-of-range reads.
        read_cell(5'd0, 7'd0);
        read_cell(5'(tcs_pkg::SCREEN_ROWS - 1), 7'(tcs_pkg::SCREEN_COLS - 1));
        read_cell(5'(tcs_pkg::SCREEN_ROWS), 7'd0);
        read_cell(5'd0, 7'(tcs_pkg::SCREEN_COLS));
        read_cell(5'h1F, 7'h7F);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(tcs_pkg::CH_BLANK);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd2);
        // Backspace from column zero goes to the end of the row above.
        put_char(tcs_pkg::CH_NEWLINE);
        put_char(tcs_pkg::CH_BACKSPACE);
        put_char(8'h7E);
        put_char(tcs_pkg::CH_BACKSPACE);
        read_cell(5'd0, 7'(tcs_pkg::SCREEN_COLS - 1));
        send_item(ACT_UNUSED, 8'hFF, 5'h1F, 7'h7F);
        send_item(tcs_pkg::ACT_CLEAR, 8'h00, 5'h00, 7'h00);
        // Backspace at the origin only blanks the home cell.
        put_char(tcs_pkg::CH_BACKSPACE);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        drain_results();

        write_attribute(8'h00);
        run_phase(0, 0, PHASE_ITEMS);
        drain_results();
        write_attribute(8'hFF);
        run_phase(58, 0, PHASE_ITEMS);
        drain_results();
        write_attribute(8'($urandom_range(255)));
        run_phase(0, 58, PHASE_ITEMS);
        drain_results();
        write_attribute(8'($urandom_range(255)));
        run_phase(23, 23, PHASE_ITEMS);
        drain_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d results over four attribute settings and idle/stall mixes.",
                 sb.checked);
        $display("Seen: %0d scrolls, %0d clears, %0d in-range cell reads.",
                 sb.scroll_count, sb.clear_count, sb.read_count);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("text_console_cursor_scroll: match");
        end
        else
        begin
            $display("text_console_cursor_scroll: mismatch");
        end
        $finish;
    end

endmodule
